// File: hw/rtl/block_jump_chain_table_defines.svh
// Assertion helpers, clocked on clk_i, off while in reset.
`ifndef BLOCK_JUMP_CHAIN_TABLE_DEFINES_SVH
`define BLOCK_JUMP_CHAIN_TABLE_DEFINES_SVH

// Property that must hold at every edge.
`define BJCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define BJCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bjct_pkg.sv
package bjct_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned BlockSizeDef  = 32;

  localparam int unsigned PosW    = 10;
  localparam int unsigned StrideW = 11;
  localparam int unsigned LenW    = 11;
  localparam int unsigned TgtW    = 12;
  localparam int unsigned CntW    = 11;

  localparam logic [CntW-1:0] CountMax = '1;
  localparam logic [LenW-1:0] LengthRst = 11'd1024;

  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_QUERY = 1'b1
  } bjct_cmd_e;

  typedef struct packed {
    bjct_cmd_e           cmd;
    logic [PosW-1:0]     pos;
    logic [StrideW-1:0]  stride;
    logic [PosW-1:0]     base;
  } bjct_item_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_BASE,
    FR_PUSH
  } bjct_front_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_WR,
    ST_SET_LINK,
    ST_LOOP_RD,
    ST_LOOP_CHK,
    ST_LOOP_WR,
    ST_Q_RD,
    ST_Q_BLK,
    ST_Q_STR,
    ST_OUT
  } bjct_back_state_e;

endpackage

// File: hw/rtl/bjct_ram.sv
module bjct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bjct_fifo.sv
module bjct_fifo import bjct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  bjct_item_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output bjct_item_t data_o
);

  bjct_item_t slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rptr_q];

endmodule

// File: hw/rtl/bjct_front.sv
module bjct_front import bjct_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned BlockSize  = BlockSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [PosW-1:0]    position_i,
  input  logic [StrideW-1:0] stride_i,
  output logic               push_o,
  output bjct_item_t         item_o,
  input  logic               full_i
);

  // floor(p / BlockSize) as p * ceil(2^K / BlockSize) >> K, exact for p < 2^PosW
  localparam int unsigned RecK  = 2 * PosW + 1;
  localparam int unsigned Recip = ((1 << RecK) + BlockSize - 1) / BlockSize;
  localparam int unsigned RecW  = RecK + 1;
  localparam int unsigned ProdW = PosW + RecW;

  bjct_front_state_e state_q, state_d;
  bjct_item_t        item_q, item_d;
  logic [PosW-1:0]   quot_q, quot_d;
  logic              accept, in_table;
  logic [ProdW-1:0]  prod;
  logic [PosW+11-1:0] base_full;

  assign in_table = (32'(position_i) < TableDepth);
  assign accept   = in_valid_i && !in_stall_o;
  assign prod      = ProdW'(item_q.pos) * ProdW'(Recip);
  assign base_full = (PosW + 11)'(quot_q) * (PosW + 11)'(BlockSize);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (accept && in_table) state_d = FR_DIV;
      FR_DIV:  state_d = FR_BASE;
      FR_BASE: state_d = FR_PUSH;
      FR_PUSH: if (!full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    item_d     = item_q;
    quot_d     = quot_q;
    in_stall_o = (state_q != FR_IDLE);
    push_o     = (state_q == FR_PUSH);
    case (state_q)
      FR_IDLE: begin
        if (accept) begin
          item_d.cmd    = bjct_cmd_e'(command_i);
          item_d.pos    = position_i;
          // a zero stride is stored as one
          item_d.stride = (stride_i == '0) ? StrideW'(1) : stride_i;
          item_d.base   = '0;
        end
      end
      FR_DIV:  quot_d = PosW'(prod >> RecK);
      FR_BASE: item_d.base = base_full[PosW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    quot_q <= quot_d;
  end

  assign item_o = item_q;

endmodule

// File: hw/rtl/bjct_back.sv
module bjct_back import bjct_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned BlockSize  = BlockSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LenW-1:0]    len_i,
  input  logic               valid_i,
  input  bjct_item_t         item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PosW-1:0]    last_position_o,
  output logic [CntW-1:0]    visit_count_o
);

`include "block_jump_chain_table_defines.svh"

  localparam int unsigned AW    = $clog2(TableDepth);
  localparam int unsigned BW    = (BlockSize > 1) ? $clog2(BlockSize) : 1;
  localparam int unsigned HopW  = $clog2(BlockSize + 1);
  localparam int unsigned LinkW = HopW + TgtW;

  bjct_back_state_e state_q, state_d;

  logic [PosW-1:0]    p_q, p_d, base_q, base_d, i_q, i_d;
  logic [StrideW-1:0] s_q, s_d;
  logic [TgtW-1:0]    cur_q, cur_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [BlockSize-1:0] marks_q, marks_d;
  logic               out_valid_q, out_valid_d;
  logic [PosW-1:0]    last_q, last_d;
  logic [CntW-1:0]    vcnt_q, vcnt_d;

  // stride memory
  logic               str_we;
  logic [AW-1:0]      str_waddr, str_raddr;
  logic [StrideW-1:0] str_rd;
  // link memory: {hop count, exit target}
  logic               lnk_we;
  logic [AW-1:0]      lnk_waddr, lnk_raddr;
  logic [LinkW-1:0]   lnk_wdata, lnk_rd;
  logic [HopW-1:0]    rd_hop;
  logic [TgtW-1:0]    rd_exit;

  logic [TgtW-1:0]    len_x, base_x, set_tgt, loop_tgt, str_eff, str_nxt;
  logic               set_leave, loop_link, blk_go, out_free;
  logic [CntW:0]      cnt_sum;
  logic [CntW-1:0]    cnt_sat, cnt_inc;

  bjct_ram #(.Width(StrideW), .Depth(TableDepth)) u_stride_ram (
    .clk_i,
    .we_i    (str_we),
    .waddr_i (str_waddr),
    .wdata_i (s_q),
    .raddr_i (str_raddr),
    .rdata_o (str_rd)
  );

  bjct_ram #(.Width(LinkW), .Depth(TableDepth)) u_link_ram (
    .clk_i,
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rd)
  );

  assign rd_hop  = lnk_rd[TgtW +: HopW];
  assign rd_exit = lnk_rd[TgtW-1:0];
  assign len_x   = TgtW'(len_i);
  assign base_x  = TgtW'(base_q);

  assign set_tgt   = TgtW'(p_q) + TgtW'(s_q);
  assign set_leave = ((set_tgt - base_x) >= TgtW'(BlockSize)) || (set_tgt >= len_x);

  assign loop_tgt  = TgtW'(i_q) + TgtW'(str_rd);
  assign loop_link = ((loop_tgt - base_x) < TgtW'(BlockSize)) && (loop_tgt < len_x) &&
                     marks_q[BW'(loop_tgt - base_x)];

  assign blk_go  = (rd_exit < len_x) && (rd_exit > cur_q);
  assign cnt_sum = (CntW+1)'(cnt_q) + (CntW+1)'(rd_hop);
  assign cnt_sat = cnt_sum[CntW] ? CountMax : cnt_sum[CntW-1:0];
  assign cnt_inc = (cnt_q == CountMax) ? CountMax : cnt_q + CntW'(1);

  assign str_eff = (str_rd == '0) ? TgtW'(1) : TgtW'(str_rd);
  assign str_nxt = cur_q + str_eff;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (valid_i) state_d = (item_i.cmd == CMD_SET) ? ST_SET_WR : ST_Q_RD;
      end
      ST_SET_WR:   state_d = set_leave ? ST_LOOP_RD : ST_SET_LINK;
      ST_SET_LINK: state_d = ST_LOOP_RD;
      ST_LOOP_RD:  state_d = (i_q == base_q) ? ST_IDLE : ST_LOOP_CHK;
      ST_LOOP_CHK: state_d = loop_link ? ST_LOOP_WR : ST_LOOP_RD;
      ST_LOOP_WR:  state_d = ST_LOOP_RD;
      ST_Q_RD:     state_d = ST_Q_BLK;
      ST_Q_BLK:    state_d = blk_go ? ST_Q_RD : ST_Q_STR;
      ST_Q_STR:    if (str_nxt >= len_x) state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    str_we      = 1'b0;
    str_waddr   = AW'(p_q);
    str_raddr   = AW'(cur_q);
    lnk_we      = 1'b0;
    lnk_waddr   = AW'(p_q);
    lnk_wdata   = {HopW'(1), set_tgt};
    lnk_raddr   = AW'(cur_q);
    p_d         = p_q;
    s_d         = s_q;
    base_d      = base_q;
    i_d         = i_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    marks_d     = marks_q;
    out_valid_d = out_valid_q && out_stall_i;
    last_d      = last_q;
    vcnt_d      = vcnt_q;
    case (state_q)
      ST_IDLE: begin
        pop_o  = valid_i;
        p_d    = item_i.pos;
        s_d    = item_i.stride;
        base_d = item_i.base;
        cur_d  = TgtW'(item_i.pos);
        cnt_d  = '0;
      end
      ST_SET_WR: begin
        str_we    = 1'b1;
        lnk_we    = set_leave;
        lnk_raddr = AW'(set_tgt);
        i_d       = p_q;
        marks_d   = '0;
        marks_d[BW'(p_q - base_q)] = 1'b1;
      end
      ST_SET_LINK: begin
        lnk_we    = 1'b1;
        lnk_wdata = {rd_hop + HopW'(1), rd_exit};
      end
      ST_LOOP_RD: begin
        str_raddr = AW'(i_q - PosW'(1));
        if (i_q != base_q) i_d = i_q - PosW'(1);
      end
      ST_LOOP_CHK: begin
        lnk_raddr = AW'(loop_tgt);
      end
      ST_LOOP_WR: begin
        lnk_we    = 1'b1;
        lnk_waddr = AW'(i_q);
        lnk_wdata = {rd_hop + HopW'(1), rd_exit};
        marks_d[BW'(i_q - base_q)] = 1'b1;
      end
      ST_Q_BLK: begin
        if (blk_go) begin
          cnt_d = cnt_sat;
          cur_d = rd_exit;
        end
      end
      ST_Q_STR: begin
        str_raddr = AW'(str_nxt);
        if (str_nxt >= len_x) begin
          cnt_d = cnt_inc;
        end else begin
          cur_d = str_nxt;
          cnt_d = cnt_inc;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = cur_q[PosW-1:0];
          vcnt_d      = cnt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      marks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      marks_q     <= marks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    s_q    <= s_d;
    base_q <= base_d;
    i_q    <= i_d;
    cur_q  <= cur_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
    vcnt_q <= vcnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign last_position_o = last_q;
  assign visit_count_o   = vcnt_q;

  `BJCT_ASSERT(a_loop_in_block, (state_q != ST_LOOP_CHK && state_q != ST_LOOP_WR) || (i_q >= base_q && i_q < p_q), "repair index left its block")
  `BJCT_ASSERT(a_walk_in_len, (state_q != ST_Q_STR && state_q != ST_OUT) || (cur_q < len_x) || (cur_q == TgtW'(p_q)), "walk position beyond length")
  `BJCT_ASSERT_NEXT(a_result_count, out_valid_q && !$past(out_valid_q), visit_count_o != '0, "result with zero visits")

endmodule

// File: hw/rtl/block_jump_chain_table.sv
// Front: takes a transfer, finds its block base and pushes it to a 2-deep queue, stalling until pushed.
// Set: writes stride and link, then relinks earlier block entries whose jump lands on a marked entry.
// Query: block jumps while the exit is ahead and in range, then stride jumps; result held in an output reg.
// Throughput is set by the back sequencer, which owns the stride and link memory ports.
// Reset: async active low; control, marks and length (1024) reset, tables undefined until set.
module block_jump_chain_table import bjct_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned BlockSize  = BlockSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: table length
  input  logic               cfg_we_i,
  input  logic [LenW-1:0]    cfg_wdata_i,
  // command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [PosW-1:0]    position_i,
  input  logic [StrideW-1:0] stride_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PosW-1:0]    last_position_o,
  output logic [CntW-1:0]    visit_count_o
);

  logic [LenW-1:0] len_q, len_d;
  logic            push, full, q_valid, pop;
  bjct_item_t      front_item, q_item;

  // length is clamped to 1..TableDepth on write
  always_comb begin
    len_d = len_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        len_d = LenW'(1);
      end else if (32'(cfg_wdata_i) > TableDepth) begin
        len_d = LenW'(TableDepth);
      end else begin
        len_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= (32'(LengthRst) > TableDepth) ? LenW'(TableDepth) : LengthRst;
    end else begin
      len_q <= len_d;
    end
  end

  // front: takes a transfer, drops positions outside the table, finds block base
  bjct_front #(.TableDepth(TableDepth), .BlockSize(BlockSize)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .position_i,
    .stride_i,
    .push_o (push),
    .item_o (front_item),
    .full_i (full)
  );

  bjct_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  // back: block repair on set, block/stride walk on query
  bjct_back #(.TableDepth(TableDepth), .BlockSize(BlockSize)) u_back (
    .clk_i,
    .rst_ni,
    .len_i   (len_q),
    .valid_i (q_valid),
    .item_i  (q_item),
    .pop_o   (pop),
    .out_valid_o,
    .out_stall_i,
    .last_position_o,
    .visit_count_o
  );

endmodule

// File: sim/chain_checker.sv
module chain_checker import bjct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LenW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               command_i,
  input  logic [PosW-1:0]    position_i,
  input  logic [StrideW-1:0] stride_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [PosW-1:0]    last_position_i,
  input  logic [CntW-1:0]    visit_count_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  localparam int unsigned Depth = TableDepthDef;
  localparam int unsigned Blk   = BlockSizeDef;

  typedef struct {
    logic [PosW-1:0] last_pos;
    logic [CntW-1:0] visits;
  } walk_res_t;

  int unsigned stride_mem [Depth];
  int unsigned exit_mem [Depth];
  int unsigned hop_mem [Depth];
  bit          marks [Blk];
  int unsigned tbl_len;
  walk_res_t   walk_q [$];

  assign pending_o = walk_q.size();

  task automatic store_stride(input int unsigned p, input int unsigned s);
    int unsigned base, t, tg;
    base = p - (p % Blk);
    t = p + s;
    stride_mem[p] = s;
    if (t - base >= Blk || t >= tbl_len) begin
      hop_mem[p] = 1;
      exit_mem[p] = t;
    end else begin
      hop_mem[p] = hop_mem[t] + 1;
      exit_mem[p] = exit_mem[t];
    end
    foreach (marks[k]) marks[k] = 1'b0;
    marks[p - base] = 1'b1;
    // relink earlier entries of the block whose jump lands on a marked entry
    for (int i = int'(p) - 1; i >= int'(base); i--) begin
      tg = i + stride_mem[i];
      if (tg - base >= Blk || tg >= tbl_len) continue;
      if (!marks[tg - base]) continue;
      hop_mem[i] = hop_mem[tg] + 1;
      exit_mem[i] = exit_mem[tg];
      marks[i - base] = 1'b1;
    end
  endtask

  function automatic walk_res_t walk_chain(input int unsigned p);
    int unsigned cur, cnt, s;
    walk_res_t r;
    cur = p;
    cnt = 0;
    // block jumps, stopping on an exit beyond the length or one that does not move forward
    while (exit_mem[cur] < tbl_len && exit_mem[cur] > cur) begin
      cnt += hop_mem[cur];
      if (cnt > 2047) cnt = 2047;
      cur = exit_mem[cur];
    end
    forever begin
      s = stride_mem[cur];
      if (s == 0) s = 1;
      if (cur + s >= tbl_len) break;
      cur += s;
      if (cnt < 2047) cnt++;
    end
    cnt++;
    if (cnt > 2047) cnt = 2047;
    r.last_pos = cur[PosW-1:0];
    r.visits = cnt[CntW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    walk_res_t want;
    int unsigned v, s;
    if (!rst_ni) begin
      tbl_len = LengthRst;
      walk_q.delete();
      fail_count_o = 0;
      foreach (marks[k]) marks[k] = 1'b0;
    end else begin
      if (cfg_we_i) begin
        v = cfg_wdata_i;
        if (v == 0) v = 1;
        if (v > Depth) v = Depth;
        tbl_len = v;
      end
      if (in_valid_i && !in_stall_i) begin
        if (bjct_cmd_e'(command_i) == CMD_SET) begin
          s = stride_i;
          if (s == 0) s = 1;
          store_stride(position_i, s);
        end else begin
          walk_q.push_back(walk_chain(position_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (walk_q.size() == 0) begin
          $error("result transfer with no query outstanding");
          fail_count_o++;
        end else begin
          want = walk_q.pop_front();
          if (last_position_i !== want.last_pos) begin
            $error("last_position: expected %0d, actual %0d", want.last_pos,
                   last_position_i);
            fail_count_o++;
          end
          if (visit_count_i !== want.visits) begin
            $error("visit_count: expected %0d, actual %0d", want.visits,
                   visit_count_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// File: sim/tb_top.sv
module tb_top import bjct_pkg::*; ();

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [LenW-1:0]    cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               command;
  logic [PosW-1:0]    position;
  logic [StrideW-1:0] stride;
  logic               out_valid;
  logic               out_stall;
  logic [PosW-1:0]    last_position;
  logic [CntW-1:0]    visit_count;
  int unsigned        fail_count;
  int unsigned        pending;

  // idle percentages of the current phase
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned cur_len;
  int unsigned idle_cycles;

  localparam int unsigned WatchdogLimit = 60000;
  localparam int unsigned DrainCycles   = 600;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  block_jump_chain_table u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .position_i     (position),
    .stride_i       (stride),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .last_position_o(last_position),
    .visit_count_o  (visit_count)
  );

  chain_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .position_i     (position),
    .stride_i       (stride),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .last_position_i(last_position),
    .visit_count_i  (visit_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // result side backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_gap_pct = 66;
        stall_pct = 0;
      end
      2: begin
        send_gap_pct = 0;
        stall_pct = 66;
      end
      default: begin
        send_gap_pct = 11;
        stall_pct = 11;
      end
    endcase
  endtask

  // one command transfer; called and returns at a falling edge
  task automatic send_cmd(input bjct_cmd_e c, input int unsigned p, input int unsigned s);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    command = c;
    position = p[PosW-1:0];
    stride = s[StrideW-1:0];
    // stall is read before the edge's updates land
    forever begin
      @(posedge clk_i);
      if (!in_stall) break;
    end
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  // length change only once all queries have answered and queued sets had time to finish
  task automatic write_length(input int unsigned v);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_wdata = v[LenW-1:0];
    @(negedge clk_i);
    cfg_we = 1'b0;
    cur_len = (v == 0) ? 1 : (v > TableDepthDef ? TableDepthDef : v);
  endtask

  function automatic int unsigned pick_stride();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 40);
    if (r < 85) return $urandom_range(1, 1024);
    return $urandom_range(0, 2047);
  endfunction

  initial begin
    int unsigned lens [8];
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    command = 1'b0;
    position = '0;
    stride = '0;
    out_stall = 1'b0;
    idle_cycles = 0;
    cur_len = TableDepthDef;
    set_idling(0);
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill every entry, lowest first, each stride leaving its block so no set
    // ever reads an entry that has not been written yet.
    for (int unsigned p = 0; p < TableDepthDef; p++) begin
      if (p % 256 == 0) set_idling(p / 256);
      send_cmd(CMD_SET, p, BlockSizeDef - (p % BlockSizeDef) + $urandom_range(0, 64));
    end

    // directed corners
    set_idling(0);
    send_cmd(CMD_QUERY, 0, 0);
    send_cmd(CMD_QUERY, 1023, 2047);
    send_cmd(CMD_SET, 5, 0);          // zero stride stored as one
    send_cmd(CMD_SET, 1023, 2047);
    send_cmd(CMD_SET, 0, 1024);
    send_cmd(CMD_SET, 31, 1);
    for (int unsigned p = 30; p > 24; p--) send_cmd(CMD_SET, p, 1);  // in-block chain
    send_cmd(CMD_QUERY, 24, 0);
    send_cmd(CMD_QUERY, 5, 0);
    send_cmd(CMD_QUERY, 512, 1);
    write_length(1);
    send_cmd(CMD_QUERY, 0, 0);
    send_cmd(CMD_QUERY, 1023, 0);     // start beyond length
    send_cmd(CMD_SET, 40, 3);         // jump leaves the table
    write_length(0);
    send_cmd(CMD_QUERY, 40, 0);
    write_length(2047);
    send_cmd(CMD_QUERY, 0, 0);
    write_length(1024);
    send_cmd(CMD_QUERY, 32, 0);

    // random phases, each with its own length and idling
    lens = '{1024, 1, 700, $urandom_range(2, 1023), 33, 2047, 0, 1024};
    for (int ph = 0; ph < 8; ph++) begin
      write_length(lens[ph]);
      set_idling(ph);
      for (int n = 0; n < 115; n++) begin
        int unsigned p;
        p = ($urandom_range(0, 99) < 80) ? $urandom_range(0, cur_len - 1)
                                         : $urandom_range(0, 1023);
        send_cmd($urandom_range(0, 1) ? CMD_QUERY : CMD_SET, p, pick_stride());
      end
    end

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bjct_pkg.sv
hw/rtl/bjct_ram.sv
hw/rtl/bjct_fifo.sv
hw/rtl/bjct_front.sv
hw/rtl/bjct_back.sv
hw/rtl/block_jump_chain_table.sv
sim/chain_checker.sv
sim/tb_top.sv
